// File: hw/rtl/two_class_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Two-class priority queue assertion macros
// Shared assertion forms for the queue's RTL checks.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Types and constants shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int TCPQ_CAPACITY = 16;
  localparam int TCPQ_ID_WIDTH = 32;
  localparam int TCPQ_IN_ID_WIDTH = 32;
  localparam int TCPQ_OUT_ID_WIDTH = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } tcpq_op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } tcpq_status_t;

  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_ENQ_HI = 2'd1,
    CMD_ENQ_LO = 2'd2,
    CMD_DEQ    = 2'd3
  } tcpq_cmd_t;

  typedef struct packed {
    logic valid;
    logic prio;
  } tcpq_tag_t;

endpackage

// File: hw/rtl/tcpq_cell.sv
// ----------------------------------------------------------------------------
// Two-class priority queue cell
// One queue slot that shifts toward the head or the tail, or loads a new word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpq_cell #(
  parameter int ID_WIDTH = tcpq_pkg::TCPQ_ID_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  tcpq_pkg::tcpq_cmd_t cmd,
  input  logic [ID_WIDTH-1:0] new_id,
  input  tcpq_pkg::tcpq_tag_t prev_tag,
  input  logic [ID_WIDTH-1:0] prev_id,
  input  tcpq_pkg::tcpq_tag_t next_tag,
  input  logic [ID_WIDTH-1:0] next_id,
  output tcpq_pkg::tcpq_tag_t tag,
  output logic [ID_WIDTH-1:0] id
);

  tcpq_pkg::tcpq_tag_t tag_next;
  logic [ID_WIDTH-1:0] id_next;

  always_comb begin
    tag_next = tag;
    id_next  = id;
    unique case (cmd)
      tcpq_pkg::CMD_ENQ_HI: begin
        if (prev_tag.valid && !prev_tag.prio) begin
          tag_next = prev_tag;
          id_next  = prev_id;
        end else if (prev_tag.valid && prev_tag.prio && !(tag.valid && tag.prio)) begin
          tag_next = '{valid: 1'b1, prio: 1'b1};
          id_next  = new_id;
        end
      end
      tcpq_pkg::CMD_ENQ_LO: begin
        if (prev_tag.valid && !tag.valid) begin
          tag_next = '{valid: 1'b1, prio: 1'b0};
          id_next  = new_id;
        end
      end
      tcpq_pkg::CMD_DEQ: begin
        tag_next = next_tag;
        id_next  = next_id;
      end
      default: begin
        tag_next = tag;
        id_next  = id;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '{valid: 1'b0, prio: 1'b0};
    end else begin
      tag <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    id <= id_next;
  end

endmodule

// File: hw/rtl/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// Two-class priority queue
// Strict-priority queue of item identifiers held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each input word either enqueues an identifier in the priority or the normal
// class, or dequeues the oldest priority item, else the oldest normal item.
// Every input word yields exactly one result word. The queue is a row of
// CAPACITY cells kept in service order: priority items first, then normal
// items, then empty cells. A priority enqueue opens a gap behind the last
// priority item, a normal enqueue fills the first empty cell, and a dequeue
// takes cell zero while every cell takes its neighbor's contents. A word is
// accepted every cycle and its result appears in the output register in the
// next cycle; only a stalled output register holds off the input.
`timescale 1ns / 1ps

`include "two_class_priority_queue_macros.svh"

module two_class_priority_queue #(
  parameter int CAPACITY = tcpq_pkg::TCPQ_CAPACITY,
  parameter int ID_WIDTH = tcpq_pkg::TCPQ_ID_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_id[31:0]
  input  logic [1:0]  s_tuser,   // op[0], is_priority[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_id[31:0], now_empty[32], zero[39:33]
  output logic [2:0]  m_tuser    // status[1:0], out_priority[2]
);

  tcpq_pkg::tcpq_tag_t tag [CAPACITY];
  logic [ID_WIDTH-1:0] id  [CAPACITY];

  tcpq_pkg::tcpq_cmd_t    cmd;
  tcpq_pkg::tcpq_op_t     in_op;
  tcpq_pkg::tcpq_status_t status_next;
  logic [ID_WIDTH-1:0]    new_id;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   now_empty_next;
  logic [CAPACITY-1:0]    valid_vec;
  logic [CAPACITY-1:0]    hi_vec;

  logic                   result_valid;
  tcpq_pkg::tcpq_status_t status;
  logic [tcpq_pkg::TCPQ_OUT_ID_WIDTH-1:0] out_id;
  logic                   out_priority;
  logic                   now_empty;

  assign in_op  = tcpq_pkg::tcpq_op_t'(s_tuser[0]);
  assign new_id = ID_WIDTH'(s_tdata);
  assign accept = s_tvalid && s_tready;
  assign full   = tag[CAPACITY-1].valid;
  assign empty  = !tag[0].valid;

  assign s_tready = !result_valid || m_tready;

  always_comb begin
    cmd            = tcpq_pkg::CMD_IDLE;
    status_next    = tcpq_pkg::ST_ENQUEUED;
    now_empty_next = 1'b0;
    priority if (in_op == tcpq_pkg::OP_DEQ && empty) begin
      status_next    = tcpq_pkg::ST_EMPTY;
      now_empty_next = 1'b1;
    end else if (in_op == tcpq_pkg::OP_DEQ) begin
      cmd            = accept ? tcpq_pkg::CMD_DEQ : tcpq_pkg::CMD_IDLE;
      status_next    = tcpq_pkg::ST_DEQUEUED;
      now_empty_next = !tag[1].valid;
    end else if (full) begin
      status_next = tcpq_pkg::ST_DROPPED;
    end else if (s_tuser[1]) begin
      cmd = accept ? tcpq_pkg::CMD_ENQ_HI : tcpq_pkg::CMD_IDLE;
    end else begin
      cmd = accept ? tcpq_pkg::CMD_ENQ_LO : tcpq_pkg::CMD_IDLE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tcpq_pkg::tcpq_tag_t prev_tag;
    logic [ID_WIDTH-1:0] prev_id;
    tcpq_pkg::tcpq_tag_t next_tag;
    logic [ID_WIDTH-1:0] next_id;

    if (i == 0) begin : g_head
      assign prev_tag = '{valid: 1'b1, prio: 1'b1};
      assign prev_id  = '0;
    end else begin : g_mid_prev
      assign prev_tag = tag[i-1];
      assign prev_id  = id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_tag = '{valid: 1'b0, prio: 1'b0};
      assign next_id  = '0;
    end else begin : g_mid_next
      assign next_tag = tag[i+1];
      assign next_id  = id[i+1];
    end

    tcpq_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .new_id   (new_id),
      .prev_tag (prev_tag),
      .prev_id  (prev_id),
      .next_tag (next_tag),
      .next_id  (next_id),
      .tag      (tag[i]),
      .id       (id[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (m_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      now_empty <= now_empty_next;
      if (cmd == tcpq_pkg::CMD_DEQ) begin
        out_id       <= tcpq_pkg::TCPQ_OUT_ID_WIDTH'(id[0]);
        out_priority <= tag[0].prio;
      end else begin
        out_id       <= '0;
        out_priority <= 1'b0;
      end
    end
  end

  assign m_tvalid = result_valid;
  assign m_tdata  = {7'd0, now_empty, out_id};
  assign m_tuser  = {out_priority, status};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = tag[i].valid;
      hi_vec[i]    = tag[i].valid && tag[i].prio;
    end
  end

  `TCPQ_ASSERT_SAME(a_valid_packed, 1'b1,
    ((valid_vec & (valid_vec + CAPACITY'(1))) == '0),
    "occupied cells are not packed toward the head")
  `TCPQ_ASSERT_SAME(a_prio_first, 1'b1,
    ((hi_vec & (hi_vec + CAPACITY'(1))) == '0),
    "a normal item stands ahead of a priority item")
  `TCPQ_ASSERT_NEXT(a_deq_result, (accept && in_op == tcpq_pkg::OP_DEQ && !empty),
    (result_valid && status == tcpq_pkg::ST_DEQUEUED),
    "dequeue from a filled queue did not report an item")
  `TCPQ_ASSERT_NEXT(a_drop_keeps, (accept && in_op == tcpq_pkg::OP_ENQ && full),
    ($stable(valid_vec) && status == tcpq_pkg::ST_DROPPED),
    "enqueue into a full queue changed the queue")

endmodule
